// ===== design/vnu_pkg.sv =====
`timescale 1ns / 1ps

package vnu_pkg;

  // Widths of the fixed port fields.
  localparam int COMP_PORT_WIDTH = 32;
  localparam int DIM_WIDTH       = 3;
  localparam int UNIT_WIDTH      = 32;
  localparam int LEN_WIDTH       = 33;

  // A unit component is Q2.30, so one is 2^30 and a quotient needs 31 bits.
  localparam int UNIT_SHIFT = 30;
  localparam int QUOT_BITS  = UNIT_SHIFT + 1;

  // Dimension codes from which the third and fourth components count.
  localparam logic [DIM_WIDTH-1:0] DIM_XYZ  = 3'd3;
  localparam logic [DIM_WIDTH-1:0] DIM_XYZW = 3'd4;

endpackage

// ===== design/vnu_sumsq.sv =====
`timescale 1ns / 1ps

module vnu_sumsq #(
  parameter int CW = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [vnu_pkg::COMP_PORT_WIDTH-1:0]  comp_x,
  input  logic [vnu_pkg::COMP_PORT_WIDTH-1:0]  comp_y,
  input  logic [vnu_pkg::COMP_PORT_WIDTH-1:0]  comp_z,
  input  logic [vnu_pkg::COMP_PORT_WIDTH-1:0]  comp_w,
  input  logic [vnu_pkg::DIM_WIDTH-1:0]        dimension,
  output logic                                 out_valid,
  output logic [3:0][CW-1:0]                   mag_out,
  output logic [3:0]                           neg_out,
  output logic [2*CW+1:0]                      sum_out
);

  logic [3:0][vnu_pkg::COMP_PORT_WIDTH-1:0] comp;
  logic [3:0][CW-1:0] mag_c;
  logic [3:0]         neg_c;

  logic [3:0]         valid;
  logic [3:0][CW-1:0] mag1, mag2, mag3;
  logic [3:0]         neg1, neg2, neg3;
  logic [3:0][2*CW-1:0] sq2;
  logic [1:0][2*CW:0]   pr3;

  assign comp = {comp_w, comp_z, comp_y, comp_x};

  // Magnitude and sign of each component; unused lanes are zero.
  always_comb begin
    logic [CW-1:0] raw;
    logic          use_lane;
    for (int i = 0; i < 4; i++) begin
      raw      = comp[i][CW-1:0];
      use_lane = (i < 2) || (i == 2 && dimension >= vnu_pkg::DIM_XYZ) ||
                 (i == 3 && dimension >= vnu_pkg::DIM_XYZW);
      neg_c[i] = use_lane & raw[CW-1];
      if (!use_lane) begin
        mag_c[i] = '0;
      end else if (raw[CW-1]) begin
        mag_c[i] = CW'(-raw);
      end else begin
        mag_c[i] = raw;
      end
    end
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[2:0], in_valid};
    end
  end

  // Stage 1 magnitudes, stage 2 squares, stage 3 pair sums, stage 4 total.
  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag_c;
      neg1 <= neg_c;
      for (int i = 0; i < 4; i++) begin
        sq2[i] <= (2*CW)'(mag1[i]) * (2*CW)'(mag1[i]);
      end
      mag2 <= mag1;
      neg2 <= neg1;
      pr3[0] <= (2*CW+1)'(sq2[0]) + (2*CW+1)'(sq2[1]);
      pr3[1] <= (2*CW+1)'(sq2[2]) + (2*CW+1)'(sq2[3]);
      mag3 <= mag2;
      neg3 <= neg2;
      sum_out <= (2*CW+2)'(pr3[0]) + (2*CW+2)'(pr3[1]);
      mag_out <= mag3;
      neg_out <= neg3;
    end
  end

  assign out_valid = valid[3];

endmodule

// ===== design/vnu_sqrt.sv =====
`timescale 1ns / 1ps

module vnu_sqrt #(
  parameter int N      = 33,
  parameter int SIDE_W = 132
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*N-1:0]    rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [N-1:0]      root,
  output logic [SIDE_W-1:0] side_out
);

  logic              v  [0:N];
  logic [N-1:0]      rt [0:N];
  logic [N+1:0]      rm [0:N];
  logic [2*N-1:0]    rd [0:N];
  logic [SIDE_W-1:0] sd [0:N];

  assign v[0]  = in_valid;
  assign rt[0] = '0;
  assign rm[0] = '0;
  assign rd[0] = rad;
  assign sd[0] = side_in;

  // One root bit per stage: bring down two radicand bits and try 4*root+1.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N+3:0] t;
    logic [N+3:0] trial;
    logic [N+3:0] diff;
    logic         ge;

    assign t     = {rm[k], rd[k][2*N-1 -: 2]};
    assign trial = {2'b00, rt[k], 2'b01};
    assign diff  = t - trial;
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[k+1] <= {rt[k][N-2:0], ge};
        rm[k+1] <= ge ? diff[N+1:0] : t[N+1:0];
        rd[k+1] <= {rd[k][2*N-3:0], 2'b00};
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = v[N];
  assign root      = rt[N];
  assign side_out  = sd[N];

endmodule

// ===== design/vnu_div.sv =====
`timescale 1ns / 1ps

module vnu_div #(
  parameter int CW = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [CW-1:0]                 mag,
  input  logic [CW:0]                   len,
  output logic                          out_valid,
  output logic [vnu_pkg::QUOT_BITS-1:0] quot
);

  localparam int QB = vnu_pkg::QUOT_BITS;
  localparam int NW = CW + QB;

  logic [NW-1:0] num;

  logic          v  [0:QB];
  logic [CW:0]   rm [0:QB];
  logic [QB-1:0] lo [0:QB];
  logic [QB-1:0] q  [0:QB];
  logic [CW:0]   ln [0:QB];

  // Rounded numerator: mag * 2^30 plus half the length.
  assign num = {1'b0, mag, {vnu_pkg::UNIT_SHIFT{1'b0}}} + NW'(len[CW:1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  // Entry stage: the upper numerator bits are already below the length.
  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= (CW+1)'(num[NW-1:QB]);
      lo[0] <= num[QB-1:0];
      q[0]  <= '0;
      ln[0] <= len;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [CW+1:0] t;
    logic [CW+1:0] diff;
    logic          ge;

    assign t    = {rm[k], lo[k][QB-1]};
    assign diff = t - {1'b0, ln[k]};
    assign ge   = (t >= {1'b0, ln[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k+1] <= ge ? diff[CW:0] : t[CW:0];
        lo[k+1] <= {lo[k][QB-2:0], 1'b0};
        q[k+1]  <= {q[k][QB-2:0], ge};
        ln[k+1] <= ln[k];
      end
    end
  end

  assign out_valid = v[QB];
  assign quot      = q[QB];

  // The final remainder must stay below a nonzero divisor.
  assert property (@(posedge clk) disable iff (rst)
    v[QB] && ln[QB] != '0 |-> rm[QB] < ln[QB])
    else $error("divider remainder not below length");

endmodule

// ===== design/vector_normalize_unit_top.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle; the whole pipeline advances unless a result is held.
// Latency is set by the square root (COMPONENT_WIDTH + 1 digit stages) and the four
// parallel divider lanes (an entry stage and 31 quotient stages), after four stages of
// squaring and summing, plus the output register.
// Reset clears the valid bits only; data registers are left as they are.

module vector_normalize_unit_top #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [vnu_pkg::COMP_PORT_WIDTH-1:0] comp_x,
  input  logic [vnu_pkg::COMP_PORT_WIDTH-1:0] comp_y,
  input  logic [vnu_pkg::COMP_PORT_WIDTH-1:0] comp_z,
  input  logic [vnu_pkg::COMP_PORT_WIDTH-1:0] comp_w,
  input  logic [vnu_pkg::DIM_WIDTH-1:0]       dimension,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [vnu_pkg::UNIT_WIDTH-1:0]      unit_x,
  output logic [vnu_pkg::UNIT_WIDTH-1:0]      unit_y,
  output logic [vnu_pkg::UNIT_WIDTH-1:0]      unit_z,
  output logic [vnu_pkg::UNIT_WIDTH-1:0]      unit_w,
  output logic [vnu_pkg::LEN_WIDTH-1:0]       length,
  output logic                                zero_vector
);

  localparam int CW     = COMPONENT_WIDTH;
  localparam int N      = CW + 1;
  localparam int QB     = vnu_pkg::QUOT_BITS;
  localparam int SIDE_W = 4 * CW + 4;
  localparam logic signed [vnu_pkg::UNIT_WIDTH-1:0] UnitOne =
    vnu_pkg::UNIT_WIDTH'(1) <<< vnu_pkg::UNIT_SHIFT;

  logic en;

  logic               ss_valid;
  logic [3:0][CW-1:0] ss_mag;
  logic [3:0]         ss_neg;
  logic [2*N-1:0]     ss_sum;

  logic               rt_valid;
  logic [N-1:0]       rt_len;
  logic [SIDE_W-1:0]  rt_side;
  logic [3:0][CW-1:0] rt_mag;
  logic [3:0]         rt_neg;

  logic [3:0]                 dv_valid;
  logic [3:0][QB-1:0]         dv_quot;
  logic [vnu_pkg::UNIT_WIDTH-1:0] unit_c [4];

  logic [N-1:0] dl_len [0:QB];
  logic [3:0]   dl_neg [0:QB];
  logic         len_zero;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  vnu_sumsq #(.CW(CW)) u_sumsq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .comp_x    (comp_x),
    .comp_y    (comp_y),
    .comp_z    (comp_z),
    .comp_w    (comp_w),
    .dimension (dimension),
    .out_valid (ss_valid),
    .mag_out   (ss_mag),
    .neg_out   (ss_neg),
    .sum_out   (ss_sum)
  );

  vnu_sqrt #(.N(N), .SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ss_valid),
    .rad       (ss_sum),
    .side_in   ({ss_neg, ss_mag}),
    .out_valid (rt_valid),
    .root      (rt_len),
    .side_out  (rt_side)
  );

  assign rt_mag = rt_side[4*CW-1:0];
  assign rt_neg = rt_side[SIDE_W-1 -: 4];

  // One divider lane per component.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    vnu_div #(.CW(CW)) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (rt_valid),
      .mag       (rt_mag[i]),
      .len       (rt_len),
      .out_valid (dv_valid[i]),
      .quot      (dv_quot[i])
    );
  end

  // Length and signs wait alongside the divider lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      dl_len[0] <= rt_len;
      dl_neg[0] <= rt_neg;
      for (int k = 1; k <= QB; k++) begin
        dl_len[k] <= dl_len[k-1];
        dl_neg[k] <= dl_neg[k-1];
      end
    end
  end

  assign len_zero = (dl_len[QB] == '0);

  // Apply the sign, and clear everything for a zero vector.
  always_comb begin
    logic [vnu_pkg::UNIT_WIDTH-1:0] uq;
    for (int i = 0; i < 4; i++) begin
      uq = {1'b0, dv_quot[i]};
      if (len_zero) begin
        unit_c[i] = '0;
      end else if (dl_neg[QB][i]) begin
        unit_c[i] = -uq;
      end else begin
        unit_c[i] = uq;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_x      <= unit_c[0];
      unit_y      <= unit_c[1];
      unit_z      <= unit_c[2];
      unit_w      <= unit_c[3];
      length      <= vnu_pkg::LEN_WIDTH'(dl_len[QB]);
      zero_vector <= len_zero;
    end
  end

  // A zero vector returns all-zero fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |->
      length == '0 && unit_x == '0 && unit_y == '0 && unit_z == '0 && unit_w == '0)
    else $error("zero vector with nonzero fields");

  // A nonzero vector has a nonzero length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !zero_vector |-> length != '0)
    else $error("zero length without zero flag");

  // Unit components x and y never exceed one in magnitude.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(unit_x) <= UnitOne && $signed(unit_x) >= -UnitOne &&
                  $signed(unit_y) <= UnitOne && $signed(unit_y) >= -UnitOne)
    else $error("unit component out of range");

endmodule

// ===== tb/vector_normalize_unit_top_tb.sv =====
`timescale 1ns / 1ps

module vector_normalize_unit_top_tb;

  localparam int LATENCY = 70;

  typedef struct packed {
    logic [vnu_pkg::UNIT_WIDTH-1:0] ux;
    logic [vnu_pkg::UNIT_WIDTH-1:0] uy;
    logic [vnu_pkg::UNIT_WIDTH-1:0] uz;
    logic [vnu_pkg::UNIT_WIDTH-1:0] uw;
    logic [vnu_pkg::LEN_WIDTH-1:0]  len;
    logic                           zero;
  } norm_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [vnu_pkg::COMP_PORT_WIDTH-1:0] comp_x, comp_y, comp_z, comp_w;
  logic [vnu_pkg::DIM_WIDTH-1:0] dimension;
  logic out_valid;
  logic out_stall;
  logic [vnu_pkg::UNIT_WIDTH-1:0] unit_x, unit_y, unit_z, unit_w;
  logic [vnu_pkg::LEN_WIDTH-1:0] length;
  logic zero_vector;

  norm_result_t expected_norms[$];
  int error_count = 0;
  int request_count = 0;
  int result_count = 0;
  int zero_count = 0;
  bit idle_enable = 1'b1;

  vector_normalize_unit_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .comp_w(comp_w),
    .dimension(dimension),
    .out_valid(out_valid), .out_stall(out_stall),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .unit_w(unit_w),
    .length(length), .zero_vector(zero_vector)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, floor, by digit-by-digit method.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Computes the normalized vector and length for one request.
  function automatic norm_result_t normalize_vector(
      input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
      input logic [31:0] cw, input logic [vnu_pkg::DIM_WIDTH-1:0] dim);
    norm_result_t r;
    logic [31:0] comps[4];
    logic [63:0] mags[4];
    logic [31:0] units[4];
    logic [31:0] negc;
    logic [64:0] sum;
    logic [63:0] len;
    logic [63:0] quot;
    int used;
    comps[0] = cx; comps[1] = cy; comps[2] = cz; comps[3] = cw;
    used = (dim < 2) ? 2 : ((dim > 4) ? 4 : int'(dim));
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      // The magnitude is taken at 32 bits, so the most negative value gives 2^31.
      negc = -comps[i];
      mags[i] = comps[i][31] ? 64'(negc) : 64'(comps[i]);
      if (i >= used) mags[i] = 0;
      sum = sum + 65'(mags[i] * mags[i]);
    end
    // A sum that overflows 64 bits only happens for the largest vector.
    len = sum[64] ? (64'd1 << 32) : floor_sqrt(sum[63:0]);
    r = '0;
    if (len == 0) begin
      r.zero = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      quot = ((mags[i] << vnu_pkg::UNIT_SHIFT) + (len >> 1)) / len;
      units[i] = (comps[i][31] && i < used) ? 32'(-quot) : 32'(quot);
    end
    r.ux = units[0]; r.uy = units[1]; r.uz = units[2]; r.uw = units[3];
    r.len = len[vnu_pkg::LEN_WIDTH-1:0];
    return r;
  endfunction

  // Sends one request and records its expected result. The valid stays high
  // afterwards, so the next request follows without a gap unless idling is inserted.
  task automatic send_vector(input logic [31:0] cx, input logic [31:0] cy,
      input logic [31:0] cz, input logic [31:0] cw,
      input logic [vnu_pkg::DIM_WIDTH-1:0] dim);
    while (idle_enable && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    comp_x    <= cx;
    comp_y    <= cy;
    comp_z    <= cz;
    comp_w    <= cw;
    dimension <= dim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_norms.push_back(normalize_vector(cx, cy, cz, cw, dim));
    request_count++;
  endtask

  // Random stall on the result side.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_enable && ($urandom_range(99) < 16);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    norm_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_norms.size() == 0) begin
        $error("unexpected result with no request pending");
        error_count++;
      end else begin
        e = expected_norms.pop_front();
        result_count++;
        if (zero_vector) zero_count++;
        if (unit_x !== e.ux) begin
          $error("unit_x expected %h actual %h", e.ux, unit_x); error_count++;
        end
        if (unit_y !== e.uy) begin
          $error("unit_y expected %h actual %h", e.uy, unit_y); error_count++;
        end
        if (unit_z !== e.uz) begin
          $error("unit_z expected %h actual %h", e.uz, unit_z); error_count++;
        end
        if (unit_w !== e.uw) begin
          $error("unit_w expected %h actual %h", e.uw, unit_w); error_count++;
        end
        if (length !== e.len) begin
          $error("length expected %h actual %h", e.len, length); error_count++;
        end
        if (zero_vector !== e.zero) begin
          $error("zero_vector expected %b actual %b", e.zero, zero_vector);
          error_count++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(512)) - 256);
      3: return 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom;
    endcase
  endfunction

  // Drops the valid and waits until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_norms.size() != 0) @(posedge clk);
  endtask

  // Field extremes, every dimension code and the named special cases.
  task automatic test_directed();
    send_vector(0, 0, 0, 0, 3'd2);
    send_vector(0, 0, 0, 0, vnu_pkg::DIM_XYZW);
    send_vector(0, 0, 32'h1234_5678, 32'hFFFF_FFFF, 3'd2);
    send_vector(32'h0001_0000, 0, 0, 0, 3'd2);
    send_vector(32'hFFFF_0000, 0, 0, 0, 3'd2);
    send_vector(0, 32'h0000_0001, 0, 0, 3'd2);
    send_vector(32'h0003_0000, 32'h0004_0000, 32'h7FFF_FFFF, 32'h8000_0000, 3'd2);
    send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h5555_5555,
                vnu_pkg::DIM_XYZ);
    send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                vnu_pkg::DIM_XYZW);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                vnu_pkg::DIM_XYZW);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                vnu_pkg::DIM_XYZ);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                vnu_pkg::DIM_XYZW);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 3'd2);
    send_vector(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                vnu_pkg::DIM_XYZW);
    send_vector(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 3'd0);
    send_vector(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 3'd1);
    send_vector(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 3'd5);
    send_vector(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 3'd6);
    send_vector(32'hFFFE_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0004_0000, 3'd7);
    send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                vnu_pkg::DIM_XYZW);
  endtask

  // Random vectors, with a pause until everything has drained midway.
  task automatic test_random(input int count);
    logic [vnu_pkg::DIM_WIDTH-1:0] dim;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      dim = ($urandom_range(9) == 0) ? vnu_pkg::DIM_WIDTH'($urandom_range(7))
                                     : vnu_pkg::DIM_WIDTH'($urandom_range(4, 2));
      send_vector(rand_comp(), rand_comp(), rand_comp(), rand_comp(), dim);
    end
  endtask

  // Back-to-back requests with no idling on either side.
  task automatic test_streaming(input int count);
    idle_enable = 1'b0;
    for (int n = 0; n < count; n++) begin
      send_vector($urandom, $urandom, $urandom, $urandom,
                  vnu_pkg::DIM_WIDTH'($urandom_range(4, 2)));
    end
    wait_drained();
    idle_enable = 1'b1;
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    comp_x    <= '0;
    comp_y    <= '0;
    comp_z    <= '0;
    comp_w    <= '0;
    dimension <= 3'd2;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(450);
    test_streaming(180);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d requests, %0d results checked, %0d zero vectors.",
             request_count, result_count, zero_count);
    if (error_count == 0 && expected_norms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_norms.size() != 0)
        $error("%0d expected results never arrived", expected_norms.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vnu_pkg.sv
design/vnu_sumsq.sv
design/vnu_sqrt.sv
design/vnu_div.sv
design/vector_normalize_unit_top.sv
tb/vector_normalize_unit_top_tb.sv
